// File: sv/cnda_pkg.sv
`timescale 1ns / 1ps
package cnda_pkg;
    localparam int VecDim = 16;
    localparam int IdxW = 4;

    localparam logic [2:0] REQ_SAMPLE  = 3'd0;
    localparam logic [2:0] REQ_ADAPT   = 3'd1;
    localparam logic [2:0] REQ_WIN     = 3'd2;
    localparam logic [2:0] REQ_DENSITY = 3'd3;
    localparam logic [2:0] REQ_WWRITE  = 3'd4;

    localparam logic KIND_DIST    = 1'b0;
    localparam logic KIND_DENSITY = 1'b1;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [3:0]         elem_index;
        logic signed [15:0] elem_value;
        logic               last_elem;
        logic               is_winner;
        logic [15:0]        mean_density;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [17:0] distance;
        logic [15:0] density;
    } out_item_t;
endpackage

// File: sv/competitive_node_distance_adapt.sv
`timescale 1ns / 1ps
// Steps: a sample element is squared and summed; for the element marked last, the distance
//   then takes 16 root steps and an output state; adapt repeats, for each of the 16
//   weights, a multiply, 33 divide steps and a write-back; density takes an add, two
//   multiplies, 48 divide steps and an output state; other items finish on acceptance.
// One item at a time: no input is taken while the node is busy or a result waits.
// Reset (rst_n, async, active low): weights and samples zero, win count one,
//   learn_rate 0.5. The 16-entry stores are cleared by reset.
module competitive_node_distance_adapt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  cnda_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output cnda_pkg::out_item_t   out_data
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_ROOT  = 4'd2;
    localparam logic [3:0] S_AMUL  = 4'd3;
    localparam logic [3:0] S_ADIV  = 4'd4;
    localparam logic [3:0] S_AWB   = 4'd5;
    localparam logic [3:0] S_DM1   = 4'd6;
    localparam logic [3:0] S_DM2   = 4'd7;
    localparam logic [3:0] S_DDIV  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_DEN0  = 4'd10;
    localparam int IW = cnda_pkg::IdxW;

    logic [3:0]  state_reg, state_next;
    logic [15:0] rate_reg;
    logic signed [15:0] wgt_reg [cnda_pkg::VecDim];
    logic signed [15:0] smp_reg [cnda_pkg::VecDim];
    logic [31:0] sum_reg;
    logic [15:0] win_reg;
    cnda_pkg::in_item_t item_reg;
    logic [IW:0] idx_reg;

    // shared serial unit: restoring divider / root, 48-bit working word
    logic [47:0] num_reg;     // dividend shifting out, or root radicand
    logic [47:0] rem_reg;
    logic [47:0] quo_reg;
    logic [47:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;

    logic        ovalid_reg;
    cnda_pkg::out_item_t odata_reg;

    logic accept;
    assign in_stall = (state_reg != S_IDLE) || ovalid_reg;
    assign accept   = in_valid && !in_stall;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    logic [15:0] m_eff;
    assign m_eff = (win_reg == 16'd0) ? 16'd1 : win_reg;

    // divider step
    logic [47:0] rem_sh;
    logic        rem_ge;
    assign rem_sh = {rem_reg[46:0], num_reg[47]};
    assign rem_ge = rem_sh >= den_reg;

    // root step (bitwise, 16 iterations over 32-bit radicand)
    logic [33:0] rt_trial;
    logic [33:0] rt_rem;
    assign rt_rem   = {rem_reg[31:0], num_reg[31:30]};
    assign rt_trial = {quo_reg[15:0], 2'b01};

    logic [IW-1:0] ai;
    assign ai = idx_reg[IW-1:0];

    logic signed [16:0] samp_diff;
    assign samp_diff = 17'(item_reg.elem_value) - 17'(wgt_reg[item_reg.elem_index]);

    logic [47:0] quo_next_div;
    assign quo_next_div = {quo_reg[46:0], rem_ge};

    logic signed [17:0] nw_full;
    logic signed [16:0] q_signed;
    assign q_signed = neg_reg ? -$signed({1'b0, quo_reg[15:0]}) : $signed({1'b0, quo_reg[15:0]});
    assign nw_full = 18'(wgt_reg[ai]) + 18'(q_signed);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_data.req_type)
                        cnda_pkg::REQ_SAMPLE:  state_next = S_SQ;
                        cnda_pkg::REQ_ADAPT:   state_next = S_AMUL;
                        cnda_pkg::REQ_DENSITY: state_next = S_DEN0;
                        default:               state_next = S_IDLE;
                    endcase
                end
            end
            S_SQ:   state_next = item_reg.last_elem ? S_ROOT : S_IDLE;
            S_ROOT: state_next = (cnt_reg == 6'd15) ? S_OUT : S_ROOT;
            S_AMUL: state_next = S_ADIV;
            S_ADIV: state_next = (cnt_reg == 6'd47) ? S_AWB : S_ADIV;
            S_AWB:  state_next = (idx_reg == (IW+1)'(cnda_pkg::VecDim - 1)) ? S_IDLE : S_AMUL;
            S_DEN0: state_next = S_DM1;
            S_DM1:  state_next = S_DM2;
            S_DM2:  state_next = S_DDIV;
            S_DDIV: state_next = (cnt_reg == 6'd47) ? S_OUT : S_DDIV;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rate_reg   <= 16'd32768;
            sum_reg    <= '0;
            win_reg    <= 16'd1;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
            item_reg   <= '0;
            idx_reg    <= '0;
            num_reg    <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            den_reg    <= '0;
            cnt_reg    <= '0;
            neg_reg    <= 1'b0;
            for (int i = 0; i < cnda_pkg::VecDim; i++)
            begin
                wgt_reg[i] <= '0;
                smp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                rate_reg <= cfg_wdata;
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            if (accept)
            begin
                item_reg <= in_data;
                if (in_data.req_type == cnda_pkg::REQ_WIN && win_reg != 16'hFFFF)
                    win_reg <= win_reg + 16'd1;
                if (in_data.req_type == cnda_pkg::REQ_WWRITE)
                    wgt_reg[in_data.elem_index] <= in_data.elem_value;
                if (in_data.req_type == cnda_pkg::REQ_ADAPT)
                    idx_reg <= '0;
            end
            unique case (state_reg)
                S_SQ:
                begin
                    // 17x17 square, saturating 32-bit add
                    begin
                        logic [33:0] sq;
                        logic [32:0] s;
                        sq = 34'($signed(samp_diff) * $signed(samp_diff));
                        s  = 33'(sum_reg) + 33'(sq);
                        smp_reg[item_reg.elem_index] <= item_reg.elem_value;
                        if (item_reg.last_elem)
                        begin
                            num_reg <= {16'd0, (s[32] ? 32'hFFFF_FFFF : s[31:0])};
                            rem_reg <= '0;
                            quo_reg <= '0;
                            cnt_reg <= '0;
                            sum_reg <= '0;
                        end
                        else
                            sum_reg <= s[32] ? 32'hFFFF_FFFF : s[31:0];
                    end
                end
                S_ROOT:
                begin
                    num_reg <= {num_reg[45:0], 2'b00};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (rt_rem >= rt_trial)
                    begin
                        rem_reg <= 48'(rt_rem - rt_trial);
                        quo_reg <= {quo_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= 48'(rt_rem);
                        quo_reg <= {quo_reg[46:0], 1'b0};
                    end
                    if (cnt_reg == 6'd15)
                    begin
                        odata_reg.result_kind <= cnda_pkg::KIND_DIST;
                        odata_reg.density     <= '0;
                        odata_reg.distance    <= {2'b00,
                            quo_reg[14:0], (rt_rem >= rt_trial)};
                    end
                end
                S_AMUL:
                begin
                    // |diff| * rate, denominator M * 65536 for the winner, M * 100 * 65536 otherwise
                    begin
                        logic signed [16:0] d;
                        logic [16:0] ad;
                        d  = 17'(smp_reg[ai]) - 17'(wgt_reg[ai]);
                        ad = d[16] ? 17'(-d) : d;
                        neg_reg <= d[16];
                        num_reg <= 48'(ad * rate_reg) << 15;
                        den_reg <= item_reg.is_winner ? (48'(m_eff) << 16) :
                                   ((48'(m_eff) * 48'd100) << 16);
                        rem_reg <= '0;
                        quo_reg <= '0;
                        cnt_reg <= 6'd15;
                    end
                end
                S_ADIV:
                begin
                    num_reg <= {num_reg[46:0], 1'b0};
                    rem_reg <= rem_ge ? rem_sh - den_reg : rem_sh;
                    quo_reg <= quo_next_div;
                    cnt_reg <= cnt_reg + 6'd1;
                end
                S_AWB:
                begin
                    if (nw_full > 18'sd32767)
                        wgt_reg[ai] <= 16'sh7FFF;
                    else if (nw_full < -18'sd32768)
                        wgt_reg[ai] <= 16'sh8000;
                    else
                        wgt_reg[ai] <= nw_full[15:0];
                    idx_reg <= idx_reg + 1'b1;
                end
                S_DEN0:
                begin
                    num_reg <= 48'(17'd4096 + 17'(item_reg.mean_density));
                end
                S_DM1:
                begin
                    num_reg <= 48'(num_reg[16:0] * num_reg[16:0]);
                end
                S_DM2:
                begin
                    // a divisor beyond 48 bits leaves a zero quotient, so clamp it
                    begin
                        logic [49:0] dprod;
                        dprod = 50'(num_reg[33:0]) * 50'(m_eff);
                        den_reg <= (dprod[49:48] != 2'b00) ? 48'hFFFF_FFFF_FFFF : dprod[47:0];
                    end
                    num_reg <= 48'h0100_0000_0000;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= '0;
                end
                S_DDIV:
                begin
                    num_reg <= {num_reg[46:0], 1'b0};
                    rem_reg <= rem_ge ? rem_sh - den_reg : rem_sh;
                    quo_reg <= quo_next_div;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd47)
                    begin
                        odata_reg.result_kind <= cnda_pkg::KIND_DENSITY;
                        odata_reg.distance    <= '0;
                        odata_reg.density     <= (quo_next_div[47:16] != 0) ?
                                                 16'hFFFF : quo_next_div[15:0];
                    end
                end
                S_OUT:
                    ovalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> in_stall)
        else $error("item taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> ovalid_reg)
        else $error("result not raised");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && out_stall) |=> $stable(odata_reg))
        else $error("result changed under stall");
endmodule

// File: bench/competitive_node_distance_adapt_tb.sv
`timescale 1ns / 1ps
module competitive_node_distance_adapt_tb;
    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles = 2000;
    localparam int HoldCycles = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    cnda_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    cnda_pkg::out_item_t out_data;

    always #1 clk = ~clk;

    competitive_node_distance_adapt uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    // Node state as the bench believes it to be
    logic signed [15:0] node_weights [cnda_pkg::VecDim];
    logic signed [15:0] node_samples [cnda_pkg::VecDim];
    logic [31:0] sq_acc;
    logic [15:0] wins;
    logic [15:0] rate;

    cnda_pkg::in_item_t pending_items[$];
    cnda_pkg::out_item_t awaited_results[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_go = 1'b0;     // asks the receiver for one long hold-off
    bit drive_on = 1'b0;

    function automatic logic [31:0] root_floor(input logic [31:0] v);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'h4000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Advance the node state by one item; queue any result it produces
    task automatic node_predict(input cnda_pkg::in_item_t it);
        longint d;
        longint acc;
        longint divisor;
        longint nw;
        longint q;
        longint m;
        logic [31:0] root;
        cnda_pkg::out_item_t res;
        m = (wins == 0) ? 1 : wins;
        res = '0;
        case (it.req_type)
            cnda_pkg::REQ_SAMPLE:
            begin
                d = longint'(it.elem_value) - longint'(node_weights[it.elem_index]);
                acc = longint'(sq_acc) + d * d;
                node_samples[it.elem_index] = it.elem_value;
                sq_acc = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
                if (it.last_elem)
                begin
                    root = root_floor(sq_acc);
                    res.result_kind = cnda_pkg::KIND_DIST;
                    res.distance = root[17:0];
                    awaited_results = {awaited_results, res};
                    sq_acc = 0;
                end
            end
            cnda_pkg::REQ_ADAPT:
            begin
                divisor = m * (it.is_winner ? 1 : 100) * 65536;
                for (int i = 0; i < cnda_pkg::VecDim; i++)
                begin
                    d = longint'(node_samples[i]) - longint'(node_weights[i]);
                    // SV division truncates toward zero, as required
                    nw = longint'(node_weights[i]) + (d * longint'(rate)) / divisor;
                    if (nw > 32767)
                        nw = 32767;
                    if (nw < -32768)
                        nw = -32768;
                    node_weights[i] = nw[15:0];
                end
            end
            cnda_pkg::REQ_WIN:
                if (wins != 16'hFFFF)
                    wins = wins + 16'd1;
            cnda_pkg::REQ_DENSITY:
            begin
                d = 4096 + longint'(it.mean_density);
                q = (64'd1 << 40) / (m * d * d);
                res.result_kind = cnda_pkg::KIND_DENSITY;
                res.density = (q > 65535) ? 16'hFFFF : q[15:0];
                awaited_results = {awaited_results, res};
            end
            cnda_pkg::REQ_WWRITE:
                node_weights[it.elem_index] = it.elem_value;
            default: ;
        endcase
    endtask

    // Driver: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                node_predict(in_data);
                void'(pending_items.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (drive_on && pending_items.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_items[0];
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: runs of stall and no stall, plus the long hold-off
    int stall_run = 0;
    bit stall_mode = 1'b0;
    int hold_left = 0;
    bit hold_armed = 1'b0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_run == 0)
            begin
                stall_mode <= ($urandom_range(0, 2) == 0);
                stall_run <= $urandom_range(1, 20);
            end
            else
                stall_run <= stall_run - 1;
            if (hold_go && !hold_armed)
            begin
                hold_armed <= 1'b1;
                hold_left <= HoldCycles;
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
            out_stall <= (hold_left > 0) | (stall_mode & ($urandom_range(0, 1) == 1));
        end
    end

    // Monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d dist=%0d dens=%0d", $time,
                             out_data.result_kind, out_data.distance, out_data.density);
                    mismatches++;
                end
                else
                begin
                    if (out_data !== awaited_results[0])
                    begin
                        $display("%0t: expected kind=%0d dist=%0d dens=%0d", $time,
                                 awaited_results[0].result_kind,
                                 awaited_results[0].distance, awaited_results[0].density);
                        $display("%0t: actual   kind=%0d dist=%0d dens=%0d", $time,
                                 out_data.result_kind, out_data.distance, out_data.density);
                        mismatches++;
                    end
                    void'(awaited_results.pop_front());
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (hold_left > 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic cnda_pkg::in_item_t make_item(input logic [2:0] req, input int idx,
                                                     input int val, input bit last,
                                                     input bit win, input int mean);
        cnda_pkg::in_item_t it;
        it.req_type = req;
        it.elem_index = idx[3:0];
        it.elem_value = val[15:0];
        it.last_elem = last;
        it.is_winner = win;
        it.mean_density = mean[15:0];
        return it;
    endfunction

    function automatic cnda_pkg::in_item_t random_item();
        cnda_pkg::in_item_t it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(cnda_pkg::in_item_t)-1:0];
        it.req_type = ($urandom_range(0, 9) < 7) ? cnda_pkg::REQ_SAMPLE
                                                 : 3'($urandom_range(0, 7));
        it.last_elem = ($urandom_range(0, 5) == 0);
        return it;
    endfunction

    task automatic queue_item(input cnda_pkg::in_item_t it);
        pending_items = {pending_items, it};
    endtask

    task automatic run_to_idle();
        wait (pending_items.size() == 0 && !in_valid);
        wait (awaited_results.size() == 0);
        // adapt may still be working with nothing expected
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic set_rate(input logic [15:0] r);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
        rate = r;
    endtask

    task automatic random_vectors(input int n);
        int s;
        for (int k = 0; k < n; k++)
        begin
            s = $urandom_range(0, 9);
            if (s < 6)
            begin
                // well-formed vector, then a possible adapt, win and density request
                for (int i = 0; i < cnda_pkg::VecDim; i++)
                    queue_item(make_item(cnda_pkg::REQ_SAMPLE, i, $urandom,
                                         i == cnda_pkg::VecDim - 1, 0, 0));
                if ($urandom_range(0, 1))
                    queue_item(make_item(cnda_pkg::REQ_ADAPT, $urandom, $urandom, 0,
                                         $urandom, $urandom));
                if ($urandom_range(0, 2) == 0)
                    queue_item(make_item(cnda_pkg::REQ_WIN, 0, 0, 0, 0, 0));
                if ($urandom_range(0, 2) == 0)
                    queue_item(make_item(cnda_pkg::REQ_DENSITY, 0, 0, 0, 0, $urandom));
            end
            else if (s < 8)
                queue_item(make_item(cnda_pkg::REQ_WWRITE, $urandom, $urandom, 0, 0, 0));
            else
                for (int i = 0; i < 4; i++)
                    queue_item(random_item());
        end
    endtask

    initial
    begin
        for (int i = 0; i < cnda_pkg::VecDim; i++)
        begin
            node_weights[i] = 0;
            node_samples[i] = 0;
        end
        sq_acc = 0;
        wins = 1;
        rate = 16'd32768;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every request, unknown types, saturation
        queue_item(make_item(cnda_pkg::REQ_DENSITY, 0, 0, 0, 0, 0));
        queue_item(make_item(cnda_pkg::REQ_DENSITY, 0, 0, 0, 0, 65535));
        queue_item(make_item(cnda_pkg::REQ_WWRITE, 0, -32768, 0, 0, 0));
        queue_item(make_item(cnda_pkg::REQ_WWRITE, 15, 32767, 0, 0, 0));
        queue_item(make_item(cnda_pkg::REQ_SAMPLE, 0, 32767, 0, 0, 0));
        queue_item(make_item(cnda_pkg::REQ_SAMPLE, 15, -32768, 0, 0, 0));
        queue_item(make_item(cnda_pkg::REQ_SAMPLE, 0, 32767, 0, 0, 0));
        queue_item(make_item(cnda_pkg::REQ_SAMPLE, 15, -32768, 0, 0, 0));
        queue_item(make_item(cnda_pkg::REQ_SAMPLE, 0, 32767, 0, 0, 0));
        queue_item(make_item(cnda_pkg::REQ_SAMPLE, 15, -32768, 1, 0, 0));
        queue_item(make_item(cnda_pkg::REQ_SAMPLE, 7, 12345, 1, 1, 0));
        queue_item(make_item(cnda_pkg::REQ_ADAPT, 0, 0, 0, 1, 0));
        queue_item(make_item(cnda_pkg::REQ_ADAPT, 0, 0, 0, 0, 0));
        queue_item(make_item(3'd5, 3, 100, 1, 1, 5));
        queue_item(make_item(3'd6, 3, 100, 1, 1, 5));
        queue_item(make_item(3'd7, 3, 100, 1, 1, 5));
        queue_item(make_item(cnda_pkg::REQ_WIN, 0, 0, 0, 0, 0));
        queue_item(make_item(cnda_pkg::REQ_DENSITY, 0, 0, 0, 0, 1000));
        queue_item(make_item(cnda_pkg::REQ_SAMPLE, 9, 4096, 1, 0, 0));
        drive_on = 1'b1;
        run_to_idle();

        set_rate(16'hFFFF);
        random_vectors(6);
        // long receiver hold-off while items keep coming
        hold_go = 1'b1;
        run_to_idle();

        set_rate(16'd0);
        random_vectors(5);
        run_to_idle();

        set_rate(16'($urandom));
        random_vectors(13);
        run_to_idle();

        // raise the win count, then back to density checks
        for (int i = 0; i < 70; i++)
            queue_item(make_item(cnda_pkg::REQ_WIN, 0, 0, 0, 0, 0));
        queue_item(make_item(cnda_pkg::REQ_DENSITY, 0, 0, 0, 0, 0));
        random_vectors(4);
        run_to_idle();

        set_rate(16'd1);
        random_vectors(4);
        run_to_idle();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: filelist.f
sv/cnda_pkg.sv
sv/competitive_node_distance_adapt.sv
bench/competitive_node_distance_adapt_tb.sv
